[design/gcc_pkg.sv]
`default_nettype none
package gcc_pkg;

   localparam int MAX_NODES = 32;
   localparam int NODE_W    = $clog2(MAX_NODES);
   localparam int CNT_W     = $clog2(MAX_NODES + 1);
   localparam int NIBBLES   = MAX_NODES / 4;

   typedef struct packed {
      logic                 valid;
      logic                 dirty;
      logic [MAX_NODES-1:0] mask;
   } token_type;

   typedef enum logic [2:0] {
      ST_LOAD = 3'b001,
      ST_WALK = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   function automatic logic [2:0] nibble_count(input logic [3:0] nib);
      logic [2:0] cnt;
      case (nib)
         4'h0: cnt = 3'd0;
         4'h1, 4'h2, 4'h4, 4'h8: cnt = 3'd1;
         4'h7, 4'hB, 4'hD, 4'hE: cnt = 3'd3;
         4'hF: cnt = 3'd4;
         default: cnt = 3'd2;
      endcase
      return cnt;
   endfunction

   function automatic logic [CNT_W-1:0] node_popcount(input logic [MAX_NODES-1:0] bits);
      logic [CNT_W-1:0] sum;
      sum = '0;
      for (int i = 0; i < NIBBLES; i++) begin
         sum = sum + CNT_W'(nibble_count(bits[4*i +: 4]));
      end
      return sum;
   endfunction

   function automatic logic [MAX_NODES-1:0] use_mask(input logic [NODE_W-1:0] last_idx);
      logic [MAX_NODES-1:0] m;
      for (int i = 0; i < MAX_NODES; i++) begin
         m[i] = (NODE_W'(i) <= last_idx);
      end
      return m;
   endfunction

endpackage
`default_nettype wire

[design/gcc_cell.sv]
`default_nettype none
module gcc_cell import gcc_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic [NODE_W-1:0]    cell_id,
   input  wire logic                 wr_en,
   input  wire logic [MAX_NODES-1:0] wr_row,
   input  wire logic [MAX_NODES-1:0] limit,
   input  wire token_type            tok_in,
   output token_type                 tok_out
);

   logic [MAX_NODES-1:0] row_ff;
   logic                 valid_ff;
   logic                 dirty_ff;
   logic                 dirty_in;
   logic [MAX_NODES-1:0] mask_ff;
   logic [MAX_NODES-1:0] mask_in;

   always_comb begin
      mask_in  = tok_in.mask | (tok_in.mask[cell_id] ? (row_ff & limit) : '0);
      dirty_in = tok_in.dirty | (mask_in != tok_in.mask);
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         row_ff <= wr_row;
      end
      mask_ff  <= mask_in;
      dirty_ff <= dirty_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= tok_in.valid;
      end
   end

   assign tok_out = '{valid: valid_ff, dirty: dirty_ff, mask: mask_ff};

endmodule
`default_nettype wire

[design/graph_connectivity_check.sv]
`default_nettype none
// Reachability check from node 0. Rows are taken one per cycle while busy is low; the row
// that completes the matrix starts a walk. A reach mask travels cell to cell along a ring
// of node_count cells (one for 0, at most 32), each cell adding its row when its node is
// already reached; the walk ends after a full lap with no growth, at most n laps for n
// nodes. Busy stays high through the walk and the done state. The result is driven for one
// cycle with rsp_strobe and cannot be held off, so take it when the strobe is seen.
module graph_connectivity_check import gcc_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   input  wire logic [31:0]          req_row_bits,
   input  wire logic                 csr_wr_en,
   input  wire logic [5:0]           csr_wr_data,
   output logic                      rsp_strobe,
   output logic                      rsp_connected,
   output logic [31:0]               rsp_reached_set,
   output logic [5:0]                rsp_reached_count
);

   state_type            state_ff, state_in;
   logic [5:0]           node_count_ff;
   logic [NODE_W-1:0]    rows_loaded_ff, rows_loaded_in;
   logic                 launch_ff, launch_in;
   logic [MAX_NODES-1:0] final_mask_ff;
   logic                 strobe_ff;
   logic                 connected_ff;
   logic [MAX_NODES-1:0] reached_ff;
   logic [CNT_W-1:0]     count_ff;
   logic [NODE_W-1:0]    last_idx;
   logic [MAX_NODES-1:0] limit;
   logic                 accept;
   logic                 last_row;
   token_type            chain_in  [MAX_NODES];
   token_type            chain_out [MAX_NODES];
   logic [MAX_NODES-1:0] tok_valid;
   token_type            tail;

   always_comb begin
      if (node_count_ff == 6'd0) begin
         last_idx = '0;
      end else if (node_count_ff >= 6'(MAX_NODES)) begin
         last_idx = NODE_W'(MAX_NODES - 1);
      end else begin
         last_idx = NODE_W'(node_count_ff - 6'd1);
      end
   end

   assign limit    = use_mask(last_idx);
   assign busy     = (state_ff != ST_LOAD);
   assign accept   = start && !busy;
   assign last_row = (rows_loaded_ff == last_idx);
   assign tail     = chain_out[last_idx];

   always_comb begin
      chain_in[0].valid = launch_ff || (state_ff == ST_WALK && tail.valid && tail.dirty);
      chain_in[0].dirty = 1'b0;
      chain_in[0].mask  = launch_ff ? MAX_NODES'(1) : tail.mask;
   end

   for (genvar k = 0; k < MAX_NODES; k++) begin : g_cell
      if (k > 0) begin : g_link
         always_comb begin
            chain_in[k]       = chain_out[k-1];
            chain_in[k].valid = chain_out[k-1].valid && (NODE_W'(k) <= last_idx);
         end
      end
      gcc_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .cell_id (NODE_W'(k)),
         .wr_en   (accept && rows_loaded_ff == NODE_W'(k)),
         .wr_row  (req_row_bits),
         .limit   (limit),
         .tok_in  (chain_in[k]),
         .tok_out (chain_out[k])
      );
      assign tok_valid[k] = chain_out[k].valid;
   end

   always_comb begin
      state_in       = state_ff;
      rows_loaded_in = rows_loaded_ff;
      launch_in      = 1'b0;
      case (state_ff)
         ST_LOAD: begin
            if (csr_wr_en) begin
               rows_loaded_in = '0;
            end else if (accept) begin
               if (last_row) begin
                  rows_loaded_in = '0;
                  launch_in      = 1'b1;
                  state_in       = ST_WALK;
               end else begin
                  rows_loaded_in = rows_loaded_ff + NODE_W'(1);
               end
            end
         end
         ST_WALK: begin
            if (tail.valid && !tail.dirty && !launch_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            state_in = ST_LOAD;
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_LOAD;
         rows_loaded_ff <= '0;
         launch_ff      <= 1'b0;
         node_count_ff  <= 6'(MAX_NODES);
         strobe_ff      <= 1'b0;
      end else begin
         state_ff       <= state_in;
         rows_loaded_ff <= rows_loaded_in;
         launch_ff      <= launch_in;
         strobe_ff      <= (state_ff == ST_DONE);
         if (csr_wr_en) begin
            node_count_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_WALK) begin
         final_mask_ff <= tail.mask;
      end
      if (state_ff == ST_DONE) begin
         connected_ff <= (final_mask_ff == limit);
         reached_ff   <= final_mask_ff;
         count_ff     <= node_popcount(final_mask_ff);
      end
   end

   assign rsp_strobe        = strobe_ff;
   assign rsp_connected     = connected_ff;
   assign rsp_reached_set   = reached_ff;
   assign rsp_reached_count = 6'(count_ff);

`ifndef SYNTHESIS
   a_one_token: assert property (@(posedge clock) disable iff (reset)
      $onehot0(tok_valid))
      else $error("more than one reach token in the ring");

   a_strobe_after_done: assert property (@(posedge clock) disable iff (reset)
      strobe_ff |-> $past(state_ff == ST_DONE))
      else $error("result transfer without finished walk");

   a_root_reached: assert property (@(posedge clock) disable iff (reset)
      strobe_ff |-> (reached_ff[0] && count_ff != '0))
      else $error("node 0 missing from reached set");

   a_csr_restart: assert property (@(posedge clock) disable iff (reset)
      (csr_wr_en && !busy) |=> (rows_loaded_ff == '0))
      else $error("row load not restarted after csr write");
`endif

endmodule
`default_nettype wire

[tb/sv/graph_connectivity_check_tb.sv]
`timescale 1ns / 100ps

module graph_connectivity_check_tb import gcc_pkg::*;;

   localparam int ROW_ITEMS    = 1500;
   localparam int LIMIT_CYCLES = 2_000_000;

   typedef enum int {
      GRAPH_DENSE,
      GRAPH_SPARSE,
      GRAPH_PATH,
      GRAPH_SPLIT,
      GRAPH_FUNNEL
   } graph_shape_type;

   typedef struct {
      logic                 connected;
      logic [MAX_NODES-1:0] reached_set;
      logic [CNT_W-1:0]     reached_count;
   } reach_summary_type;

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   logic [31:0]          req_row_bits;
   logic                 csr_wr_en;
   logic [5:0]           csr_wr_data;
   logic                 rsp_strobe;
   logic                 rsp_connected;
   logic [31:0]          rsp_reached_set;
   logic [5:0]           rsp_reached_count;

   logic [5:0]           node_count_cfg;
   int                   rows_loaded_cnt;
   logic [31:0]          loaded_rows [MAX_NODES];
   logic [31:0]          graph_rows [MAX_NODES];
   reach_summary_type    expected_reach [$];

   int                   error_count;
   int                   rows_sent;
   int                   summaries_checked;
   int                   connected_seen;
   int                   csr_writes;
   int                   cycle_count;
   bit                   burst_mode;

   graph_connectivity_check dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_row_bits      (req_row_bits),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .rsp_strobe        (rsp_strobe),
      .rsp_connected     (rsp_connected),
      .rsp_reached_set   (rsp_reached_set),
      .rsp_reached_count (rsp_reached_count)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("** graph_connectivity_check: FAILED **");
         $finish;
      end
   end

   function automatic int nodes_in_play(logic [5:0] value);
      if (value == 0) return 1;
      if (value > MAX_NODES) return MAX_NODES;
      return int'(value);
   endfunction

   function automatic logic [31:0] span_mask(int n);
      if (n >= 32) return '1;
      return (32'h1 << n) - 32'h1;
   endfunction

   task automatic predict_row(input logic [31:0] row);
      int                   n;
      logic [MAX_NODES-1:0] limit;
      logic [MAX_NODES-1:0] reach;
      logic [MAX_NODES-1:0] grown;
      reach_summary_type    summary;
      n = nodes_in_play(node_count_cfg);
      if (rows_loaded_cnt >= n) rows_loaded_cnt = 0;
      loaded_rows[rows_loaded_cnt] = row;
      rows_loaded_cnt++;
      if (rows_loaded_cnt < n) return;
      rows_loaded_cnt = 0;
      limit = span_mask(n);
      reach = 1;
      for (int pass = 0; pass < n; pass++) begin
         grown = reach;
         for (int i = 0; i < n; i++) begin
            if (reach[i]) grown = grown | (loaded_rows[i] & limit);
         end
         reach = grown;
      end
      summary.connected     = (reach == limit);
      summary.reached_set   = reach;
      summary.reached_count = CNT_W'($countones(reach));
      expected_reach.push_back(summary);
   endtask

   always @(posedge clock) begin : check_reach
      reach_summary_type want;
      if (!reset && rsp_strobe) begin
         if (expected_reach.size() == 0) begin
            $error("result transfer with no expectation: set %h count %0d",
                   rsp_reached_set, rsp_reached_count);
            error_count++;
         end else begin
            want = expected_reach.pop_front();
            summaries_checked++;
            if (rsp_connected) connected_seen++;
            if (rsp_connected !== want.connected) begin
               $error("connected: expected %0d, actual %0d", want.connected, rsp_connected);
               error_count++;
            end
            if (rsp_reached_set !== want.reached_set) begin
               $error("reached_set: expected %h, actual %h",
                      want.reached_set, rsp_reached_set);
               error_count++;
            end
            if (rsp_reached_count !== want.reached_count) begin
               $error("reached_count: expected %0d, actual %0d",
                      want.reached_count, rsp_reached_count);
               error_count++;
            end
         end
      end
   end

   function automatic int next_gap();
      int r;
      if (burst_mode) return 0;
      r = $urandom_range(99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(3, 1);
      return $urandom_range(60, 10);
   endfunction

   task automatic send_row(input logic [31:0] row);
      @(negedge clock);
      start        <= 1'b1;
      req_row_bits <= row;
      do @(posedge clock); while (busy);
      predict_row(row);
      rows_sent++;
   endtask

   task automatic hold_sender(input int cycles);
      if (cycles == 0) return;
      @(negedge clock);
      start        <= 1'b0;
      req_row_bits <= $urandom;
      repeat (cycles - 1) @(negedge clock);
   endtask

   // hold until every summary is back and the block has had time to finish a walk
   task automatic settle_block();
      int n;
      n = nodes_in_play(node_count_cfg);
      @(negedge clock);
      start <= 1'b0;
      while (expected_reach.size() != 0) @(posedge clock);
      repeat (n * n + 8) @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic write_node_count(input logic [5:0] value);
      settle_block();
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      csr_wr_data <= 6'($urandom);
      node_count_cfg  = value;
      rows_loaded_cnt = 0;
      csr_writes++;
   endtask

   task automatic send_graph(input int n);
      for (int i = 0; i < n; i++) begin
         send_row(graph_rows[i]);
         hold_sender(next_gap());
      end
   endtask

   task automatic build_graph(input int n, input graph_shape_type shape);
      logic [31:0] limit;
      logic [31:0] part;
      int          order [MAX_NODES];
      int          j;
      int          swap;
      limit = span_mask(n);
      part  = ($urandom | 32'h1) & limit;
      for (int i = 0; i < MAX_NODES; i++) begin
         graph_rows[i] = '0;
         order[i]      = i;
      end
      for (int k = n - 1; k > 1; k--) begin
         j        = $urandom_range(k, 1);
         swap     = order[k];
         order[k] = order[j];
         order[j] = swap;
      end
      for (int i = 0; i < n; i++) begin
         case (shape)
            GRAPH_DENSE:  graph_rows[i] = $urandom;
            GRAPH_SPARSE: graph_rows[i] = (n > 8) ? ($urandom & $urandom & $urandom & $urandom)
                                                  : ($urandom & $urandom);
            GRAPH_SPLIT:  graph_rows[i] = $urandom & (part[i] ? part : ~part);
            GRAPH_FUNNEL: graph_rows[i] = (i == 0) ? ($urandom & $urandom) : 32'h1;
            default:      graph_rows[i] = '0;
         endcase
      end
      if (shape == GRAPH_PATH) begin
         j = ($urandom_range(3) == 0) ? $urandom_range(n, 0) : n;
         for (int k = 0; k < n - 1; k++) begin
            if (k != j) begin
               graph_rows[order[k]] |= 32'h1 << order[k + 1];
               if ($urandom_range(1)) graph_rows[order[k + 1]] |= 32'h1 << order[k];
            end
         end
      end
      if ($urandom_range(1)) begin
         for (int i = 0; i < n; i++) graph_rows[i] |= $urandom & ~limit;
      end
   endtask

   task automatic test_default_size();
      graph_rows[0] = 32'h8000_0000;
      for (int i = 1; i < MAX_NODES; i++) graph_rows[i] = 32'h1 << (i - 1);
      send_graph(MAX_NODES);
   endtask

   task automatic test_single_node();
      write_node_count(6'd1);
      send_row(32'h0000_0000);
      send_row(32'hFFFF_FFFF);
      write_node_count(6'd0);
      send_row(32'h0000_0002);
   endtask

   task automatic test_two_nodes();
      write_node_count(6'd2);
      send_row(32'h0000_0000);
      send_row(32'h0000_0000);
      send_row(32'h0000_0002);
      hold_sender(3);
      send_row(32'h0000_0000);
      send_row(32'h0000_0000);
      send_row(32'h0000_0001);
      send_row(32'hFFFF_FFFC);
      send_row(32'hFFFF_FFFC);
      send_row(32'h0000_0003);
      send_row(32'h0000_0003);
   endtask

   task automatic test_partial_matrix();
      write_node_count(6'd3);
      send_row(32'h0000_0002);
      send_row(32'h0000_0004);
      write_node_count(6'd3);
      send_row(32'h0000_0004);
      send_row(32'h0000_0000);
      send_row(32'h0000_0002);
   endtask

   task automatic test_size_clamp();
      write_node_count(6'd63);
      graph_rows[0] = 32'hFFFF_FFFF;
      for (int i = 1; i < MAX_NODES; i++) graph_rows[i] = '0;
      send_graph(MAX_NODES);
   endtask

   task automatic test_random_graphs();
      int r;
      int n;
      int graphs;
      int first_row;
      first_row = rows_sent;
      while (rows_sent - first_row < ROW_ITEMS) begin
         r = $urandom_range(99);
         if (r < 55)      write_node_count(6'($urandom_range(8, 1)));
         else if (r < 80) write_node_count(6'($urandom_range(31, 9)));
         else if (r < 88) write_node_count(6'd32);
         else if (r < 92) write_node_count(6'd0);
         else             write_node_count(6'($urandom_range(63, 33)));
         n          = nodes_in_play(node_count_cfg);
         graphs     = (n <= 8) ? $urandom_range(10, 2) : $urandom_range(3, 1);
         burst_mode = ($urandom_range(3) == 0);
         for (int g = 0; g < graphs; g++) begin
            build_graph(n, graph_shape_type'($urandom_range(GRAPH_FUNNEL, GRAPH_DENSE)));
            send_graph(n);
         end
         // drop a partial matrix; the next size write discards it
         if (n > 1 && $urandom_range(4) == 0) begin
            build_graph(n, GRAPH_DENSE);
            send_graph($urandom_range(n - 1, 1));
         end
         burst_mode = 1'b0;
      end
   endtask

   initial begin
      clock               = 1'b0;
      reset               = 1'b1;
      start               = 1'b0;
      req_row_bits        = '0;
      csr_wr_en           = 1'b0;
      csr_wr_data         = '0;
      node_count_cfg      = 6'd32;
      rows_loaded_cnt     = 0;
      error_count         = 0;
      rows_sent           = 0;
      summaries_checked   = 0;
      connected_seen      = 0;
      csr_writes          = 0;
      cycle_count         = 0;
      burst_mode          = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_default_size();
      test_single_node();
      test_two_nodes();
      test_partial_matrix();
      test_size_clamp();
      test_random_graphs();
      settle_block();

      if (expected_reach.size() != 0) begin
         $error("%0d summaries never arrived", expected_reach.size());
         error_count++;
      end
      $display("Sent %0d row transfers over %0d size writes; checked %0d summaries (%0d connected).",
               rows_sent, csr_writes, summaries_checked, connected_seen);
      $display("Graph sizes 0 to 63 (clamped), dense, sparse, path, split and funnel shapes.");
      if (error_count == 0) begin
         $display("** graph_connectivity_check: PASSED **");
      end else begin
         $display("** graph_connectivity_check: FAILED **");
      end
      $finish;
   end

endmodule
